// ===== rtl/semv_pkg.sv =====
// ----------------------------------------------------------------------------
// semv_pkg
// Shared types, codes and constant tables of the sound-effect voice mixer.
// ----------------------------------------------------------------------------
package semv_pkg;

  typedef enum logic [1:0] {
    OP_MIX     = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_WRITE   = 2'd2,
    OP_VOICE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  // One slot handed to the scaling unit, aligned with the sample read data.
  typedef struct packed {
    logic       hit;    // add this slot into the running value
    logic       music;  // take the music sample instead of memory data
    logic [2:0] code;   // divisor minus one
  } mix_op_t;

  localparam logic signed [17:0] LIMIT_POS = 18'sd32767;
  localparam logic signed [17:0] LIMIT_NEG = -18'sd32767;

  // Reciprocal of the divisor, ceil(2^(16+l)/d) with l = ceil(log2 d).
  function automatic logic [16:0] recip_mult(input logic [2:0] code);
    logic [16:0] m;
    case (code)
      3'd2:    m = 17'd87382;   // 3
      3'd4:    m = 17'd104858;  // 5
      3'd5:    m = 17'd87382;   // 6
      3'd6:    m = 17'd74899;   // 7
      default: m = 17'd65536;   // 1, 2, 4, 8
    endcase
    return m;
  endfunction

  // Shift after the multiply: 16 + l, plus one more for the final halving.
  function automatic logic [4:0] scale_shift(input logic [2:0] code);
    logic [4:0] s;
    case (code)
      3'd0:          s = 5'd17;
      3'd1:          s = 5'd18;
      3'd2, 3'd3:    s = 5'd19;
      default:       s = 5'd20;
    endcase
    return s;
  endfunction

  // Divisor code held by each voice after reset.
  function automatic logic [2:0] reset_div_code(input int v);
    logic [2:0] c;
    if (v < 6)       c = 3'd5;  // 6
    else if (v < 9)  c = 3'd3;  // 4
    else if (v < 14) c = 3'd0;  // 1
    else if (v == 14) c = 3'd1; // 2
    else             c = 3'd3;  // 4
    return c;
  endfunction

endpackage

// ===== rtl/semv_if.sv =====
// ----------------------------------------------------------------------------
// semv_if
// Valid/ready channels of the sound-effect voice mixer: command in, result out.
// ----------------------------------------------------------------------------
interface semv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] base_sample;
  logic signed [15:0] music_sample;
  logic               music_valid;
  logic [4:0]         voice;
  logic [15:0]        mem_addr;
  logic signed [15:0] mem_data;
  logic [15:0]        voice_start;
  logic [16:0]        voice_length;
  logic [3:0]         voice_divisor;

  modport source (
    output valid, op, base_sample, music_sample, music_valid, voice,
           mem_addr, mem_data, voice_start, voice_length, voice_divisor,
    input  ready
  );
  modport sink (
    input  valid, op, base_sample, music_sample, music_valid, voice,
           mem_addr, mem_data, voice_start, voice_length, voice_divisor,
    output ready
  );
endinterface

interface semv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;
  logic [16:0]        active_mask;

  modport source (output valid, mixed_sample, active_mask, input ready);
  modport sink   (input valid, mixed_sample, active_mask, output ready);
endinterface

// ===== rtl/semv_ram.sv =====
// ----------------------------------------------------------------------------
// semv_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module semv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/semv_mix_unit.sv =====
// ----------------------------------------------------------------------------
// semv_mix_unit
// Shared scale-and-accumulate unit: divide by the voice divisor and by two
// (reciprocal multiply), then add into the running value with saturation.
// ----------------------------------------------------------------------------
module semv_mix_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  semv_pkg::mix_op_t   slot,
  input  logic signed [15:0]  mem_data,
  input  logic signed [15:0]  music_sample,
  input  logic                load,
  input  logic signed [15:0]  base_sample,
  output logic signed [15:0]  acc
);

  logic signed [15:0] operand;
  logic [15:0]        mag;
  logic [32:0]        prod_nxt;

  logic               hit2_r;
  logic               neg2_r;
  logic [2:0]         code2_r;
  logic [32:0]        prod2_r;

  logic [14:0]        quot;
  logic [17:0]        addend;
  logic signed [17:0] sum;
  logic signed [15:0] acc_r;
  logic signed [15:0] acc_nxt;

  // Stage 2: magnitude times reciprocal
  always_comb begin
    operand  = slot.music ? music_sample : mem_data;
    mag      = operand[15] ? 16'(-operand) : operand;
    prod_nxt = 33'(mag) * 33'(semv_pkg::recip_mult(slot.code));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit2_r <= 1'b0;
    end else begin
      hit2_r <= slot.hit;
    end
    neg2_r  <= operand[15];
    code2_r <= slot.code;
    prod2_r <= prod_nxt;
  end

  // Stage 3: shift, restore sign, add and clamp
  always_comb begin
    quot    = 15'(prod2_r >> semv_pkg::scale_shift(code2_r));
    addend  = neg2_r ? 18'(-{3'b000, quot}) : {3'b000, quot};
    sum     = $signed({{2{acc_r[15]}}, acc_r} + addend);
    acc_nxt = acc_r;
    if (load) begin
      acc_nxt = base_sample;
    end else if (hit2_r) begin
      if (sum > semv_pkg::LIMIT_POS) begin
        acc_nxt = 16'(semv_pkg::LIMIT_POS);
      end else if (sum < semv_pkg::LIMIT_NEG) begin
        acc_nxt = 16'(semv_pkg::LIMIT_NEG);
      end else begin
        acc_nxt = 16'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== rtl/sound_effect_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// sound_effect_voice_mixer
// A multi-voice sound-effect mixer with saturating accumulation.
//
// Software loads sample words (op 2) and per-voice descriptors (op 3: start,
// length, divisor 1..8), and triggers a voice (op 1) to restart it at
// position zero. A mix beat (op 0) walks the voices in ascending order; each
// active voice adds its sample divided by its divisor and halved, truncating
// toward zero, to the base sample, clamped to +/-32767 after every addition,
// then advances and stops at its length. The music sample, if present, is
// added last the same way. Every input beat yields one output beat carrying
// the mixed sample (zero for ops 1-3) and the mask of playing voices.
// A mix beat issues one voice per cycle into a three-stage path of sample
// memory read, reciprocal multiply and saturating add, and the final music
// slot plus the drain of the path close the walk. Other ops skip the walk.
// The block takes one beat at a time; in_ch.ready is high only while idle.
// A finished result waits in the output register while the next beat is
// already accepted. Sample memory is SAMPLE_DEPTH words (a power of two) and
// is not cleared; descriptor and position tables reset at once.
// ----------------------------------------------------------------------------
module sound_effect_voice_mixer #(
  parameter int NUM_VOICES   = 17,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  semv_in_if.sink           in_ch,
  semv_out_if.source        out_ch
);

  localparam int VW       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int IW       = $clog2(NUM_VOICES + 3);
  localparam int AW       = $clog2(SAMPLE_DEPTH);
  localparam int MASK_W   = 17;
  localparam logic [IW-1:0] MUSIC_IDX = IW'(NUM_VOICES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_VOICES + 2);

  semv_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;

  // Voice tables
  logic [15:0] start_r [NUM_VOICES];
  logic [16:0] len_r   [NUM_VOICES];
  logic [2:0]  div_r   [NUM_VOICES];
  logic [16:0] pos_r   [NUM_VOICES];
  logic        act_r   [NUM_VOICES];

  // Latched item fields
  logic               is_mix_r;
  logic signed [15:0] music_r;
  logic               music_valid_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_mixed_r;
  logic [16:0]        out_mask_r;
  logic               out_load;

  logic               accept;
  logic               voice_ok;
  logic [VW-1:0]      in_vid;
  logic [VW-1:0]      vid;
  logic               walking;
  logic               music_slot;
  logic               hit;
  logic [16:0]        pos_inc;
  logic [3:0]         div_clamped;
  logic [17:0]        rd_sum;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               mem_we;
  logic [15:0]        rd_data;

  semv_pkg::mix_op_t  slot_nxt, slot_r;
  logic signed [15:0] acc;
  logic [16:0]        mask_now;

  assign in_ch.ready = (state_r == semv_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign voice_ok    = {1'b0, in_ch.voice} < 6'(NUM_VOICES);
  assign in_vid      = VW'(in_ch.voice);

  // Walk decode: the counter runs over the voices, the music slot and then
  // the drain of the arithmetic path
  assign vid        = idx_r[VW-1:0];
  assign walking    = (state_r == semv_pkg::ST_WALK) && (idx_r < MUSIC_IDX);
  assign music_slot = (state_r == semv_pkg::ST_WALK) && (idx_r == MUSIC_IDX);
  assign hit        = walking && act_r[vid] && (pos_r[vid] < len_r[vid]);
  assign pos_inc    = pos_r[vid] + 17'd1;

  always_comb begin
    div_clamped = in_ch.voice_divisor;
    if (div_clamped == 4'd0) begin
      div_clamped = 4'd1;
    end else if (div_clamped > 4'd8) begin
      div_clamped = 4'd8;
    end
  end

  // Sample memory: write from op 2, read start + position for the walk
  assign rd_sum  = {2'b00, start_r[vid]} + {1'b0, pos_r[vid]};
  assign rd_addr = AW'(rd_sum % SAMPLE_DEPTH);
  assign wr_addr = AW'(in_ch.mem_addr % SAMPLE_DEPTH);
  assign mem_we  = accept && (in_ch.op == semv_pkg::OP_WRITE);

  semv_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (in_ch.mem_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Slot descriptor, registered to line up with the read data
  always_comb begin
    slot_nxt.hit   = hit || (music_slot && music_valid_r);
    slot_nxt.music = music_slot;
    slot_nxt.code  = music_slot ? 3'd0 : div_r[vid];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  semv_mix_unit u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .slot         (slot_r),
    .mem_data     ($signed(rd_data)),
    .music_sample (music_r),
    .load         (accept && (in_ch.op == semv_pkg::OP_MIX)),
    .base_sample  (in_ch.base_sample),
    .acc          (acc)
  );

  // Voice tables: descriptor writes and triggers come from accepted beats,
  // advance and stop come from the walk; the two never overlap in time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        start_r[v] <= '0;
        len_r[v]   <= '0;
        div_r[v]   <= semv_pkg::reset_div_code(v);
        pos_r[v]   <= '0;
        act_r[v]   <= 1'b0;
      end
    end else begin
      if (accept && voice_ok && (in_ch.op == semv_pkg::OP_TRIGGER)) begin
        pos_r[in_vid] <= '0;
        act_r[in_vid] <= 1'b1;
      end
      if (accept && voice_ok && (in_ch.op == semv_pkg::OP_VOICE)) begin
        start_r[in_vid] <= in_ch.voice_start;
        len_r[in_vid]   <= in_ch.voice_length;
        div_r[in_vid]   <= 3'(div_clamped - 4'd1);
      end
      if (walking && act_r[vid]) begin
        if (pos_r[vid] < len_r[vid]) begin
          // advance; stop when the new position reaches the length
          pos_r[vid] <= pos_inc;
          act_r[vid] <= (pos_inc < len_r[vid]);
        end else begin
          act_r[vid] <= 1'b0;
        end
      end
    end
  end

  // Hold the fields the walk needs after the beat is gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_mix_r      <= 1'b0;
      music_valid_r <= 1'b0;
    end else if (accept) begin
      is_mix_r      <= (in_ch.op == semv_pkg::OP_MIX);
      music_valid_r <= in_ch.music_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      music_r <= in_ch.music_sample;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    out_load  = 1'b0;
    unique case (state_r)
      semv_pkg::ST_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          state_nxt = (in_ch.op == semv_pkg::OP_MIX) ? semv_pkg::ST_WALK
                                                     : semv_pkg::ST_FIN;
        end
      end
      semv_pkg::ST_WALK: begin
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = semv_pkg::ST_FIN;
        end
      end
      semv_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = semv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = semv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= semv_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Playing mask, voices 0..16 only
  generate
    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
      if (g < NUM_VOICES) begin : g_live
        assign mask_now[g] = act_r[g];
      end else begin : g_none
        assign mask_now[g] = 1'b0;
      end
    end
  endgenerate

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mixed_r <= is_mix_r ? acc : 16'sd0;
      out_mask_r  <= mask_now;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mixed_sample = out_mixed_r;
  assign out_ch.active_mask  = out_mask_r;

endmodule
